@@ hdl/pss_pkg.sv @@
// Shared types, constants and control codes of the pulse speed smoother.
package pss_pkg;

   // Field widths
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned TIME_W   = 32;
   localparam int unsigned SPEED_W  = 16;
   localparam int unsigned WIN_W    = 16;
   localparam int unsigned RATE_W   = 26;
   localparam int unsigned WEIGHT_W = 17;
   localparam int unsigned CSR_W    = 32;
   localparam int unsigned STEP_W   = 3;
   localparam int unsigned DCNT_W   = 5;
   localparam int unsigned ACC_W    = 34;

   // Constants
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE    = 17'd65536;
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET  = 17'd19661;
   localparam logic [TIME_W-1:0]   TIMEOUT_RESET = 32'd200000;
   localparam logic [TIME_W-1:0]   NO_INTERVAL   = 32'hFFFF_FFFF;
   localparam logic [RATE_W-1:0]   MS_PER_SEC    = 26'd1000;
   localparam logic [ACC_W-1:0]    ROUND_HALF    = 34'd32768;
   localparam logic [DCNT_W-1:0]   DIV_STEPS     = 5'd26;

   // Register indexes
   localparam logic CSR_EMA_WEIGHT       = 1'b0;
   localparam logic CSR_ACTIVITY_TIMEOUT = 1'b1;

   // Commands
   localparam logic CMD_SAMPLE     = 1'b0;
   localparam logic CMD_CLEAR_PEAK = 1'b1;

   typedef struct packed {
      logic                command;
      logic [COUNT_W-1:0]  window_pulses;
      logic [TIME_W-1:0]   last_pulse_time;
      logic [TIME_W-1:0]   min_interval;
      logic [SPEED_W-1:0]  raw_speed;
      logic [WIN_W-1:0]    window_length;
      logic [TIME_W-1:0]   time_now;
   } req_type;

   typedef struct packed {
      logic [RATE_W-1:0]   pulse_rate;
      logic                sensor_live;
      logic [SPEED_W-1:0]  speed_now;
      logic [SPEED_W-1:0]  speed_peak;
      logic [TIME_W-1:0]   interval_held;
   } rsp_type;

   // Datapath operations selected by the microcode
   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL_NEW,
      OP_MUL_OLD,
      OP_DIV,
      OP_UPDATE,
      OP_CLR_PEAK
   } op_type;

   // Branch and hold conditions
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_CLEAR_CMD,
      COND_DIV_MORE,
      COND_OUT_BUSY
   } cond_type;

   // Sequencer to datapath
   typedef struct packed {
      op_type op;
      logic   exec;
   } seq_ctl_type;

   // Datapath to sequencer
   typedef struct packed {
      logic no_req;
      logic clear_cmd;
      logic div_more;
      logic out_busy;
   } seq_stat_type;

endpackage

@@ hdl/pss_sequencer.sv @@
// Microcode ROM and step counter of the pulse speed smoother.
module pss_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  pss_pkg::seq_stat_type stat,
   output pss_pkg::seq_ctl_type  ctl
);
   import pss_pkg::*;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic              hold;
      logic [STEP_W-1:0] target;
   } uword_type;

   // Program addresses
   localparam logic [STEP_W-1:0] STEP_LOAD  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_CMD   = 3'd1;
   localparam logic [STEP_W-1:0] STEP_MULN  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_MULO  = 3'd3;
   localparam logic [STEP_W-1:0] STEP_DIV   = 3'd4;
   localparam logic [STEP_W-1:0] STEP_OUT   = 3'd5;
   localparam logic [STEP_W-1:0] STEP_RET   = 3'd6;
   localparam logic [STEP_W-1:0] STEP_CLR   = 3'd7;

   logic [STEP_W-1:0] pc_ff, pc_in;
   uword_type         uword;
   logic              cond_true;

   // Control store
   always_comb begin
      unique case (pc_ff)
         STEP_LOAD: uword = '{OP_LOAD,     COND_NO_REQ,    1'b1, STEP_LOAD};
         STEP_CMD:  uword = '{OP_NOP,      COND_CLEAR_CMD, 1'b0, STEP_CLR};
         STEP_MULN: uword = '{OP_MUL_NEW,  COND_NEVER,     1'b0, STEP_LOAD};
         STEP_MULO: uword = '{OP_MUL_OLD,  COND_NEVER,     1'b0, STEP_LOAD};
         STEP_DIV:  uword = '{OP_DIV,      COND_DIV_MORE,  1'b0, STEP_DIV};
         STEP_OUT:  uword = '{OP_UPDATE,   COND_OUT_BUSY,  1'b1, STEP_OUT};
         STEP_RET:  uword = '{OP_NOP,      COND_ALWAYS,    1'b0, STEP_LOAD};
         STEP_CLR:  uword = '{OP_CLR_PEAK, COND_ALWAYS,    1'b0, STEP_LOAD};
      endcase
   end

   // Condition select
   always_comb begin
      unique case (uword.cond)
         COND_NEVER:     cond_true = 1'b0;
         COND_ALWAYS:    cond_true = 1'b1;
         COND_NO_REQ:    cond_true = stat.no_req;
         COND_CLEAR_CMD: cond_true = stat.clear_cmd;
         COND_DIV_MORE:  cond_true = stat.div_more;
         COND_OUT_BUSY:  cond_true = stat.out_busy;
         default:        cond_true = 1'b0;
      endcase
   end

   // A hold step waits on itself with its operation suppressed
   assign ctl.op   = uword.op;
   assign ctl.exec = !(uword.hold && cond_true);
   assign pc_in    = cond_true ? uword.target : pc_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_LOAD;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

@@ hdl/pss_datapath.sv @@
// Datapath of the pulse speed smoother: operands, multiply, divide and state.
module pss_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  pss_pkg::seq_ctl_type          ctl,
   output pss_pkg::seq_stat_type         stat,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  pss_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pss_pkg::rsp_type              rsp_data,
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [pss_pkg::CSR_W-1:0]     csr_wdata
);
   import pss_pkg::*;

   // Configuration
   logic [WEIGHT_W-1:0] weight_ff;
   logic [TIME_W-1:0]   timeout_ff;

   // Item operands and work registers
   req_type             item_ff;
   logic                active_ff;
   logic [ACC_W-1:0]    acc_ff;
   logic [RATE_W-1:0]   quo_ff;
   logic [WIN_W-1:0]    rem_ff;
   logic [DCNT_W-1:0]   dcnt_ff;

   // Persistent state
   logic [SPEED_W-1:0]  smooth_ff;
   logic [SPEED_W-1:0]  peak_ff;
   logic [TIME_W-1:0]   held_ff;

   // Result register
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic [WEIGHT_W-1:0] weight_sat;
   logic [ACC_W-1:0]    prod;
   logic [TIME_W-1:0]   elapsed;
   logic                active_in;
   logic [WIN_W+1:0]    div_diff;
   logic [SPEED_W-1:0]  speed_in;
   logic [SPEED_W-1:0]  peak_in;
   logic [TIME_W-1:0]   held_in;
   logic [RATE_W-1:0]   rate_in;
   logic                do_op;

   assign do_op = ctl.exec;

   // Weight above one acts as one
   assign weight_sat = (weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : weight_ff;

   // One shared multiplier: new sample weight or old estimate weight
   always_comb begin
      if (ctl.op == OP_MUL_NEW) begin
         prod = ACC_W'(weight_sat) * ACC_W'(item_ff.raw_speed);
      end else begin
         prod = ACC_W'(WEIGHT_ONE - weight_sat) * ACC_W'(smooth_ff);
      end
   end

   // Activity: pulses seen, or last pulse within the timeout (wrapping time)
   assign elapsed   = item_ff.time_now - item_ff.last_pulse_time;
   assign active_in = (item_ff.window_pulses != '0) ||
                      ((item_ff.last_pulse_time != '0) && (elapsed < timeout_ff));

   // Restoring divide step: shift in next dividend bit, trial subtract
   assign div_diff = {1'b0, rem_ff, quo_ff[RATE_W-1]} - {2'b00, item_ff.window_length};

   // Final update values
   assign speed_in = active_ff ? acc_ff[2*SPEED_W-1:SPEED_W] : '0;
   assign peak_in  = (active_ff && (speed_in > peak_ff)) ? speed_in : peak_ff;
   assign held_in  = (item_ff.min_interval != NO_INTERVAL) ? item_ff.min_interval : held_ff;
   assign rate_in  = (item_ff.window_length == '0) ? '0 : quo_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff  <= WEIGHT_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_EMA_WEIGHT:       weight_ff  <= csr_wdata[WEIGHT_W-1:0];
            CSR_ACTIVITY_TIMEOUT: timeout_ff <= csr_wdata[TIME_W-1:0];
         endcase
      end
   end

   // Work registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (do_op) begin
         unique case (ctl.op)
            OP_LOAD: begin
               if (req_valid) begin
                  item_ff <= req_data;
                  quo_ff  <= RATE_W'(req_data.window_pulses) * MS_PER_SEC;
                  rem_ff  <= '0;
                  dcnt_ff <= DIV_STEPS;
               end
            end
            OP_MUL_NEW: begin
               acc_ff    <= prod;
               active_ff <= active_in;
            end
            OP_MUL_OLD: begin
               acc_ff <= acc_ff + prod + ROUND_HALF;
            end
            OP_DIV: begin
               if (!div_diff[WIN_W+1]) begin
                  rem_ff <= div_diff[WIN_W-1:0];
                  quo_ff <= {quo_ff[RATE_W-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[WIN_W-2:0], quo_ff[RATE_W-1]};
                  quo_ff <= {quo_ff[RATE_W-2:0], 1'b0};
               end
               dcnt_ff <= dcnt_ff - 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff <= '0;
         peak_ff   <= '0;
         held_ff   <= '0;
      end else if (do_op) begin
         unique case (ctl.op)
            OP_UPDATE: begin
               smooth_ff <= speed_in;
               peak_ff   <= peak_in;
               held_ff   <= held_in;
            end
            OP_CLR_PEAK: begin
               peak_ff <= '0;
            end
            default: begin
            end
         endcase
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_op && (ctl.op == OP_UPDATE)) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_op && (ctl.op == OP_UPDATE)) begin
         rsp_ff.pulse_rate    <= rate_in;
         rsp_ff.sensor_live   <= active_ff;
         rsp_ff.speed_now     <= speed_in;
         rsp_ff.speed_peak    <= peak_in;
         rsp_ff.interval_held <= held_in;
      end
   end

   // Status to the sequencer
   assign stat.no_req    = !req_valid;
   assign stat.clear_cmd = (item_ff.command == CMD_CLEAR_PEAK);
   assign stat.div_more  = (dcnt_ff != DCNT_W'(1));
   assign stat.out_busy  = rsp_valid_ff && rsp_stall;

   assign req_stall = (ctl.op != OP_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ hdl/pulse_speed_smoother.sv @@
// Pulse speed smoother top level: microcode sequencer, datapath and checks.
//
// Takes one measurement window per sample and returns pulses per second, an
// activity flag, the smoothed speed (EMA with a Q1.16 weight, zeroed when
// inactive), the held peak speed and the last valid minimum pulse interval.
// A clear command zeroes the peak and returns nothing. A sample or a clear
// command occupies the block, with its input stalled, until the microcode
// program returns to its load step; the program forms the pulse rate in 26
// iterations of the one-bit restoring divider. A finished result waits in an
// output register, so the next sample can be taken while it is still stalled;
// the program only waits if a new result is ready before the old one has been
// transferred.
module pulse_speed_smoother (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  pss_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output pss_pkg::rsp_type           rsp_data,
   input  logic                       csr_write_en,
   input  logic                       csr_index,
   input  logic [pss_pkg::CSR_W-1:0]  csr_wdata
);
   import pss_pkg::*;

   seq_ctl_type  ctl;
   seq_stat_type stat;

   pss_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .ctl   (ctl)
   );

   pss_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .stat         (stat),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

`ifndef SYNTHESIS
   // One item at a time: after a transfer in, the input is stalled
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not stalled after transfer");

   // Peak never below the current smoothed speed
   a_peak_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.speed_peak >= rsp_data.speed_now))
      else $error("peak below current speed");

   // Inactive signal reports zero speed
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.sensor_live) |-> (rsp_data.speed_now == '0))
      else $error("nonzero speed while inactive");
`endif

endmodule
